### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for the RTL; sample on clk, mute in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a same-cycle implication.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/swat_pkg.sv
// ----------------------------------------------------------------------------
// swat_pkg
// Shared types and codes of the section window address translator.
// ----------------------------------------------------------------------------
package swat_pkg;

	// Request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_V2F   = 2'd1;
	localparam logic [1:0] REQ_F2V   = 2'd2;

	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} swat_state_t;

	// One section window as kept in the table
	typedef struct packed {
		logic [ADDR_W-1:0] virt_base;
		logic [ADDR_W-1:0] virt_size;
		logic [ADDR_W-1:0] raw_base;
		logic [ADDR_W-1:0] raw_size;
	} swat_entry_t;

	// Controller to datapath commands
	typedef struct packed {
		logic start;
		logic wr_en;
		logic rd_en;
		logic capture;
		logic load_out;
	} swat_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic match;
		logic s1_valid;
		logic out_free;
	} swat_stat_t;

endpackage

### hw/rtl/swat_ctrl.sv
// ----------------------------------------------------------------------------
// swat_ctrl
// Request sequencer: accepts items, walks the section table, hands off results.
// ----------------------------------------------------------------------------
module swat_ctrl #(
	parameter int MAX_SECTIONS = 16,
	parameter int AW = 4,
	parameter int CW = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic [3:0]                    entry_index,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [swat_pkg::COUNT_W-1:0]  cfg_data,
	input  swat_pkg::swat_stat_t          stat,
	output swat_pkg::swat_cmd_t           cmd,
	output logic [AW-1:0]                 rd_addr
);
	import swat_pkg::*;

	swat_state_t          state_q, state_d;
	logic [COUNT_W-1:0]   count_q;
	logic [CW-1:0]        cnt_q, cnt_d;
	logic [CW-1:0]        lim_q, lim_d;
	logic [CW-1:0]        lim_c;
	logic                 accept;

	// Clamp the active count to the table depth
	always_comb begin
		if (int'(count_q) > MAX_SECTIONS)
			lim_c = CW'(MAX_SECTIONS);
		else
			lim_c = CW'(count_q);
	end

	assign accept  = in_valid && !in_stall;
	assign rd_addr = cnt_q[AW-1:0];

	// Hold the section count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (cfg_valid && cfg_ready)
			count_q <= cfg_data;
	end

	// State and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			lim_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			lim_q   <= lim_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		lim_d    = lim_q;
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.start = 1'b1;
					unique case (req_type) inside
						REQ_WRITE: begin
							cmd.wr_en = (int'(entry_index) < MAX_SECTIONS);
							state_d   = ST_DONE;
						end
						REQ_V2F, REQ_F2V: begin
							cnt_d   = '0;
							lim_d   = lim_c;
							state_d = ST_SCAN;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				// Stop on the first match; else issue the next read, or end once the last read shows no match
				if (stat.match) begin
					cmd.capture = 1'b1;
					state_d     = ST_DONE;
				end else if (cnt_q == lim_q) begin
					if (!stat.s1_valid)
						state_d = ST_DONE;
				end else begin
					cmd.rd_en = 1'b1;
					cnt_d     = cnt_q + CW'(1);
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### hw/rtl/swat_dp.sv
// ----------------------------------------------------------------------------
// swat_dp
// Section table memory, window compare, offset arithmetic and result register.
// ----------------------------------------------------------------------------
module swat_dp #(
	parameter int MAX_SECTIONS = 16,
	parameter int AW = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  swat_pkg::swat_cmd_t          cmd,
	output swat_pkg::swat_stat_t         stat,
	input  logic [AW-1:0]                rd_addr,
	input  logic [1:0]                   req_type,
	input  logic [3:0]                   entry_index,
	input  logic [swat_pkg::ADDR_W-1:0]  virt_base,
	input  logic [swat_pkg::ADDR_W-1:0]  virt_size,
	input  logic [swat_pkg::ADDR_W-1:0]  raw_base,
	input  logic [swat_pkg::ADDR_W-1:0]  raw_size,
	input  logic [swat_pkg::ADDR_W-1:0]  query_addr,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [swat_pkg::ADDR_W-1:0]  result_addr,
	output logic                         hit
);
	import swat_pkg::*;

	swat_entry_t         mem [MAX_SECTIONS];
	swat_entry_t         ent_s1;
	logic                valid_s1;
	logic [1:0]          req_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                hit_s2;
	logic [ADDR_W-1:0]   diff_s2;
	logic [ADDR_W-1:0]   tob_s2;
	logic [ADDR_W-1:0]   lo_c, size_c, to_c, hi_c;
	logic                out_valid_q;

	// Write one table entry, read one per scan cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[AW'(entry_index)] <= '{virt_base, virt_size, raw_base, raw_size};
		if (cmd.rd_en)
			ent_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= cmd.rd_en;
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q  <= req_type;
			addr_q <= query_addr;
		end
	end

	// Pick the window side by direction
	always_comb begin
		case (req_q)
			REQ_F2V: begin
				lo_c   = ent_s1.raw_base;
				size_c = ent_s1.raw_size;
				to_c   = ent_s1.virt_base;
			end
			default: begin
				lo_c   = ent_s1.virt_base;
				size_c = ent_s1.virt_size;
				to_c   = ent_s1.raw_base;
			end
		endcase
	end

	// Window test; the end wraps at 32 bits
	assign hi_c       = lo_c + size_c;
	assign stat.match = valid_s1 && (lo_c <= addr_q) && (hi_c > addr_q);

	// Hold the matched window's offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hit_s2 <= 1'b0;
		else if (cmd.start)
			hit_s2 <= 1'b0;
		else if (cmd.capture)
			hit_s2 <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			diff_s2 <= addr_q - lo_c;
			tob_s2  <= to_c;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_addr <= hit_s2 ? (diff_s2 + tob_s2) : '0;
			hit         <= hit_s2;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.s1_valid = valid_s1;
	assign stat.out_free = !out_valid_q || !out_stall;

endmodule

### hw/rtl/section_window_address_translator.sv
// ----------------------------------------------------------------------------
// section_window_address_translator: a translate scans up to N table entries
// (N = active entries); the next item is taken the cycle after the result is loaded.
// One comparator walks one table entry per cycle behind a registered memory read.
// Reset clears control state and the section count; table contents stay undefined.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module section_window_address_translator #(
	parameter int MAX_SECTIONS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   req_type,
	input  logic [3:0]                   entry_index,
	input  logic [swat_pkg::ADDR_W-1:0]  virt_base,
	input  logic [swat_pkg::ADDR_W-1:0]  virt_size,
	input  logic [swat_pkg::ADDR_W-1:0]  raw_base,
	input  logic [swat_pkg::ADDR_W-1:0]  raw_size,
	input  logic [swat_pkg::ADDR_W-1:0]  query_addr,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [swat_pkg::ADDR_W-1:0]  result_addr,
	output logic                         hit,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [swat_pkg::COUNT_W-1:0] cfg_data
);
	import swat_pkg::*;

	localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CW = $clog2(MAX_SECTIONS + 1);

	swat_cmd_t       cmd;
	swat_stat_t      stat;
	logic [AW-1:0]   rd_addr;

	// Register writes are always taken
	assign cfg_ready = 1'b1;

	swat_ctrl #(
		.MAX_SECTIONS(MAX_SECTIONS),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.entry_index(entry_index),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.stat       (stat),
		.cmd        (cmd),
		.rd_addr    (rd_addr)
	);

	swat_dp #(
		.MAX_SECTIONS(MAX_SECTIONS),
		.AW(AW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.rd_addr    (rd_addr),
		.req_type   (req_type),
		.entry_index(entry_index),
		.virt_base  (virt_base),
		.virt_size  (virt_size),
		.raw_base   (raw_base),
		.raw_size   (raw_size),
		.query_addr (query_addr),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result_addr(result_addr),
		.hit        (hit)
	);

	// One item in flight at a time
	`ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "item accepted while busy")
	// Table is never written during a scan
	`ASSERT_SAME(a_no_wr_in_scan, cmd.wr_en, !cmd.rd_en, "table write during scan")
	// Scan ends on the first match
	`ASSERT_NEXT(a_first_match, cmd.capture, !cmd.capture && !cmd.rd_en, "scan went on after a match")
	// Never overwrite a result that is still held
	`ASSERT_SAME(a_no_overwrite, cmd.load_out, !(out_valid && out_stall), "held result overwritten")

endmodule
